### rtl/cube_step_chain_coder_macros.svh
`ifndef CUBE_STEP_CHAIN_CODER_MACROS_SVH
`define CUBE_STEP_CHAIN_CODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/csc_pkg.sv
`timescale 1ns / 1ps
package csc_pkg;

  localparam int COORD_BITS_DEF   = 24;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int INV_BITS         = 16;
  localparam int PROD_FRAC        = 24;
  localparam int CODE_BITS        = 5;
  localparam int CNT_OUT_BITS     = 16;
  localparam int QUEUE_DEPTH_LOG2 = 2;

  localparam logic [INV_BITS-1:0] INV_RESET = 16'd13107;

  typedef enum logic [1:0] {
    KIND_STEP = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic first_pt;
    logic final_pt;
  } pt_flags_t;

endpackage

### rtl/csc_front.sv
`timescale 1ns / 1ps
module csc_front #(
  parameter int COORD_BITS = csc_pkg::COORD_BITS_DEF,
  parameter int ITEM_W     = 3 * (COORD_BITS + csc_pkg::INV_BITS + 2 - csc_pkg::PROD_FRAC) + 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [csc_pkg::INV_BITS-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_BITS-1:0]     in_x_coord,
  input  logic signed [COORD_BITS-1:0]     in_y_coord,
  input  logic signed [COORD_BITS-1:0]     in_z_coord,
  input  csc_pkg::pt_flags_t               in_flags,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ITEM_W-1:0]                out_item
);

  localparam int INV_W  = csc_pkg::INV_BITS;
  localparam int PROD_W = COORD_BITS + INV_W;
  localparam int IDX_W  = PROD_W + 1 - csc_pkg::PROD_FRAC;
  localparam int CUBE_W = IDX_W + 1;
  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(1) << (csc_pkg::PROD_FRAC - 1);

  logic [INV_W-1:0]       inv_r;
  logic [COORD_BITS-1:0]  coord   [3];
  logic [COORD_BITS-1:0]  mag     [3];
  logic [PROD_W-1:0]      prod_nxt[3];
  logic [PROD_W:0]        rnd     [3];
  logic [IDX_W-1:0]       idx     [3];
  logic [CUBE_W-1:0]      cube_nxt[3];

  logic                   s1_v_r;
  logic [PROD_W-1:0]      s1_prod_r[3];
  logic [2:0]             s1_neg_r;
  csc_pkg::pt_flags_t     s1_flags_r;

  logic                   s2_v_r;
  logic [CUBE_W-1:0]      s2_cube_r[3];
  csc_pkg::pt_flags_t     s2_flags_r;

  logic                   s1_adv;
  logic                   s2_adv;

  assign coord[0] = in_x_coord;
  assign coord[1] = in_y_coord;
  assign coord[2] = in_z_coord;

  // sign-magnitude snap: |c| * inv, round half up, sign restored
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]      = coord[i][COORD_BITS-1] ? (~coord[i] + COORD_BITS'(1)) : coord[i];
      prod_nxt[i] = PROD_W'(mag[i]) * PROD_W'(inv_r);
      rnd[i]      = (PROD_W + 1)'(s1_prod_r[i]) + HALF;
      idx[i]      = IDX_W'(rnd[i] >> csc_pkg::PROD_FRAC);
      cube_nxt[i] = s1_neg_r[i] ? (~CUBE_W'(idx[i]) + CUBE_W'(1)) : CUBE_W'(idx[i]);
    end
  end

  assign s2_adv   = !s2_v_r || out_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r  <= csc_pkg::INV_RESET;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        inv_r <= cfg_wdata;
      end
      if (s1_adv) begin
        s1_v_r <= in_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_prod_r[i] <= prod_nxt[i];
        s1_neg_r[i]  <= coord[i][COORD_BITS-1];
      end
      s1_flags_r <= in_flags;
    end
    if (s2_adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_cube_r[i] <= cube_nxt[i];
      end
      s2_flags_r <= s1_flags_r;
    end
  end

  assign out_valid = s2_v_r;
  assign out_item  = {s2_cube_r[0], s2_cube_r[1], s2_cube_r[2], s2_flags_r};

endmodule

### rtl/csc_fifo.sv
`timescale 1ns / 1ps
module csc_fifo #(
  parameter int WIDTH      = 8,
  parameter int DEPTH_LOG2 = csc_pkg::QUEUE_DEPTH_LOG2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr_r;
  logic [DEPTH_LOG2-1:0] rd_ptr_r;
  logic [DEPTH_LOG2:0]   cnt_r;
  logic [DEPTH_LOG2:0]   cnt_nxt;
  logic                  push;
  logic                  pop;

  assign push_ready = cnt_r != (DEPTH_LOG2 + 1)'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/csc_back.sv
`timescale 1ns / 1ps
`include "cube_step_chain_coder_macros.svh"
module csc_back #(
  parameter int COORD_BITS = csc_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = csc_pkg::COUNT_BITS_DEF,
  parameter int ITEM_W     = 3 * (COORD_BITS + csc_pkg::INV_BITS + 2 - csc_pkg::PROD_FRAC) + 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ITEM_W-1:0]                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output csc_pkg::result_kind_t              out_kind,
  output logic [csc_pkg::CODE_BITS-1:0]      out_code,
  output logic [csc_pkg::CNT_OUT_BITS-1:0]   out_count,
  output logic                               out_last
);

  localparam int CUBE_W = COORD_BITS + csc_pkg::INV_BITS + 2 - csc_pkg::PROD_FRAC;
  localparam int DIFF_W = CUBE_W + 1;
  localparam int CB     = csc_pkg::CODE_BITS;

  logic [CUBE_W-1:0]      cube [3];
  csc_pkg::pt_flags_t     flags;

  logic [CUBE_W-1:0]      prev_r   [3];
  logic [CUBE_W-1:0]      prev_nxt [3];
  logic [CB-1:0]          lc_r, lc_nxt;
  logic                   lcv_r, lcv_nxt;
  logic                   failed_r, failed_nxt;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_nxt;

  logic [DIFF_W-1:0]      diff  [3];
  logic [1:0]             digit [3];
  logic [2:0]             in_rng;
  logic [2:0]             nz;
  logic                   step_ok;
  logic                   moved;
  logic [CB-1:0]          code;
  logic                   code_new;
  logic                   take;

  logic                   res_v;
  csc_pkg::result_kind_t  res_kind;
  logic [CB-1:0]          res_code;
  logic [COUNT_BITS-1:0]  res_cnt;
  logic                   res_last;
  logic                   res_pend;

  logic                   out_v_r;
  csc_pkg::result_kind_t  out_kind_r;
  logic [CB-1:0]          out_code_r;
  logic [COUNT_BITS-1:0]  out_cnt_r;
  logic                   out_last_r;
  logic                   pend_v_r;
  logic [COUNT_BITS-1:0]  pend_cnt_r;
  logic                   slot_free;

  assign {cube[0], cube[1], cube[2], flags} = in_item;

  // step classification against the previous cube
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]   = {cube[i][CUBE_W-1], cube[i]} - {prev_r[i][CUBE_W-1], prev_r[i]};
      in_rng[i] = (diff[i] == '0) || (diff[i] == DIFF_W'(1)) || (diff[i] == '1);
      nz[i]     = diff[i] != '0;
      digit[i]  = diff[i][1:0] + 2'd1;
    end
    step_ok = &in_rng;
    moved   = |nz;
    code    = CB'(digit[0]) + CB'(3) * CB'(digit[1]) + CB'(9) * CB'(digit[2]);
  end

  assign slot_free = !out_v_r || out_ready;
  assign in_ready  = !pend_v_r && slot_free;
  assign take      = in_valid && in_ready;
  assign code_new  = moved && !(lcv_r && code == lc_r);

  always_comb begin
    prev_nxt   = prev_r;
    lc_nxt     = lc_r;
    lcv_nxt    = lcv_r;
    failed_nxt = failed_r;
    cnt_nxt    = cnt_r;
    res_v      = 1'b0;
    res_kind   = csc_pkg::KIND_STEP;
    res_code   = '0;
    res_cnt    = '0;
    res_last   = 1'b0;
    res_pend   = 1'b0;
    if (take) begin
      if (flags.first_pt) begin
        prev_nxt   = cube;
        lc_nxt     = '0;
        lcv_nxt    = 1'b0;
        failed_nxt = 1'b0;
        cnt_nxt    = '0;
        if (flags.final_pt) begin
          res_v    = 1'b1;
          res_kind = csc_pkg::KIND_DONE;
          res_last = 1'b1;
        end
      end else if (!failed_r) begin
        if (!step_ok) begin
          failed_nxt = 1'b1;
          res_v      = 1'b1;
          res_kind   = csc_pkg::KIND_FAIL;
          res_last   = 1'b1;
        end else begin
          prev_nxt = cube;
          if (code_new) begin
            lc_nxt  = code;
            lcv_nxt = 1'b1;
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            res_v    = 1'b1;
            res_code = code;
            res_last = !flags.final_pt;
            res_pend = flags.final_pt;
          end else if (flags.final_pt) begin
            res_v    = 1'b1;
            res_kind = csc_pkg::KIND_DONE;
            res_cnt  = cnt_r;
            res_last = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
      lc_r     <= '0;
      lcv_r    <= 1'b0;
      failed_r <= 1'b0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      prev_r   <= prev_nxt;
      lc_r     <= lc_nxt;
      lcv_r    <= lcv_nxt;
      failed_r <= failed_nxt;
      cnt_r    <= cnt_nxt;
      if (slot_free) begin
        if (pend_v_r) begin
          out_v_r  <= 1'b1;
          pend_v_r <= 1'b0;
        end else begin
          out_v_r  <= res_v;
          pend_v_r <= res_pend;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_v_r) begin
        out_kind_r <= csc_pkg::KIND_DONE;
        out_code_r <= '0;
        out_cnt_r  <= pend_cnt_r;
        out_last_r <= 1'b1;
      end else begin
        out_kind_r <= res_kind;
        out_code_r <= res_code;
        out_cnt_r  <= res_cnt;
        out_last_r <= res_last;
        pend_cnt_r <= cnt_nxt;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_kind  = out_kind_r;
  assign out_code  = out_code_r;
  assign out_count = csc_pkg::CNT_OUT_BITS'(out_cnt_r);
  assign out_last  = out_last_r;

  `CSC_ASSERT_NOW(a_pend_behind_step, pend_v_r, out_v_r && out_kind_r == csc_pkg::KIND_STEP && !out_last_r, "done beat pending without a step beat ahead")
  `CSC_ASSERT_NOW(a_fail_marks_chain, out_v_r && out_kind_r == csc_pkg::KIND_FAIL, failed_r, "fail beat shown while chain not marked failed")
  `CSC_ASSERT_NOW(a_step_is_last_code, out_v_r && out_kind_r == csc_pkg::KIND_STEP, lcv_r && lc_r == out_code_r, "step beat differs from last code")
  `CSC_ASSERT_NEXT(a_first_clears_count, take && flags.first_pt, cnt_r == '0 && !failed_r, "chain start did not clear count")

endmodule

### rtl/cube_step_chain_coder.sv
`timescale 1ns / 1ps
// channel   ports                     beat taken when
// cfg       cfg_we, cfg_wdata         cfg_we high, no wait
// in        in_valid / in_ready       in_valid && in_ready, one point per beat
// out       out_valid / out_ready     out_valid && out_ready, one result per beat
//
// one point per cycle in while the queue is not full;
// a point that ends its chain with a new step code gives two result beats, every other point one or none
// from input beat to result a point passes the two multiply/round stages,
// the four-entry queue and the output register
// rst_n synchronous, active low; no clearing pass
// the queue lets the snap pipeline run while the output is stalled
module cube_step_chain_coder #(
  parameter int COORD_BITS = csc_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = csc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [csc_pkg::INV_BITS-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_BITS-1:0]      in_x_coord,
  input  logic signed [COORD_BITS-1:0]      in_y_coord,
  input  logic signed [COORD_BITS-1:0]      in_z_coord,
  input  logic                              in_chain_first,
  input  logic                              in_chain_final,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_result_kind,
  output logic [csc_pkg::CODE_BITS-1:0]     out_step_code,
  output logic [csc_pkg::CNT_OUT_BITS-1:0]  out_code_count,
  output logic                              out_last_of_run
);

  localparam int CUBE_W = COORD_BITS + csc_pkg::INV_BITS + 2 - csc_pkg::PROD_FRAC;
  localparam int ITEM_W = 3 * CUBE_W + 2;

  csc_pkg::pt_flags_t     flags;
  logic                   fr_valid, fr_ready;
  logic [ITEM_W-1:0]      fr_item;
  logic                   bk_valid, bk_ready;
  logic [ITEM_W-1:0]      bk_item;
  csc_pkg::result_kind_t  kind;

  assign flags.first_pt = in_chain_first;
  assign flags.final_pt = in_chain_final;

  csc_front #(
    .COORD_BITS (COORD_BITS),
    .ITEM_W     (ITEM_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_x_coord (in_x_coord),
    .in_y_coord (in_y_coord),
    .in_z_coord (in_z_coord),
    .in_flags   (flags),
    .out_valid  (fr_valid),
    .out_ready  (fr_ready),
    .out_item   (fr_item)
  );

  csc_fifo #(
    .WIDTH      (ITEM_W),
    .DEPTH_LOG2 (csc_pkg::QUEUE_DEPTH_LOG2)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_item),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_item)
  );

  csc_back #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .ITEM_W     (ITEM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (bk_valid),
    .in_ready   (bk_ready),
    .in_item    (bk_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (kind),
    .out_code   (out_step_code),
    .out_count  (out_code_count),
    .out_last   (out_last_of_run)
  );

  assign out_result_kind = kind;

endmodule

### tb/chain_code_checker.sv
`timescale 1ns / 1ps
module chain_code_checker (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [csc_pkg::INV_BITS-1:0]               cfg_wdata,
  input  logic                                       in_valid,
  input  logic                                       in_ready,
  input  logic signed [csc_pkg::COORD_BITS_DEF-1:0]  in_x_coord,
  input  logic signed [csc_pkg::COORD_BITS_DEF-1:0]  in_y_coord,
  input  logic signed [csc_pkg::COORD_BITS_DEF-1:0]  in_z_coord,
  input  logic                                       in_chain_first,
  input  logic                                       in_chain_final,
  input  logic                                       out_valid,
  input  logic                                       out_ready,
  input  logic [1:0]                                 out_result_kind,
  input  logic [csc_pkg::CODE_BITS-1:0]              out_step_code,
  input  logic [csc_pkg::CNT_OUT_BITS-1:0]           out_code_count,
  input  logic                                       out_last_of_run,
  output int unsigned                                mismatches,
  output int unsigned                                pending_results,
  output int unsigned                                step_beats,
  output int unsigned                                done_beats,
  output int unsigned                                fail_beats
);

  localparam int COORD_W     = csc_pkg::COORD_BITS_DEF;
  localparam int CUBE_BITS   = COORD_W + csc_pkg::INV_BITS + 1 - csc_pkg::PROD_FRAC;
  localparam int SCALED_BITS = COORD_W + csc_pkg::INV_BITS + 1;

  typedef struct packed {
    csc_pkg::result_kind_t                kind;
    logic [csc_pkg::CODE_BITS-1:0]        code;
    logic [csc_pkg::CNT_OUT_BITS-1:0]     count;
    logic                                 last;
  } chain_result_t;

  chain_result_t                          expected_chain_results[$];
  logic [csc_pkg::INV_BITS-1:0]           inverse_size;
  logic signed [CUBE_BITS-1:0]            prev_cube[3];
  logic [csc_pkg::CODE_BITS-1:0]          last_code;
  logic                                   last_code_valid;
  logic                                   chain_failed;
  logic [csc_pkg::COUNT_BITS_DEF-1:0]     code_total;

  function automatic logic signed [CUBE_BITS-1:0] snap_to_cube(
    input logic signed [COORD_W-1:0]        coord,
    input logic [csc_pkg::INV_BITS-1:0]     inv
  );
    logic [COORD_W-1:0]          mag;
    logic [SCALED_BITS-1:0]      scaled;
    logic signed [CUBE_BITS-1:0] idx;
    mag = coord[COORD_W-1] ? -coord : coord;
    // round half away from zero on the magnitude
    scaled = mag * inv + (1 << (csc_pkg::PROD_FRAC - 1));
    idx = scaled[csc_pkg::PROD_FRAC +: CUBE_BITS];
    return coord[COORD_W-1] ? -idx : idx;
  endfunction

  task automatic push_result(
    input csc_pkg::result_kind_t              kind,
    input logic [csc_pkg::CODE_BITS-1:0]      code,
    input logic [csc_pkg::CNT_OUT_BITS-1:0]   count,
    input logic                               last
  );
    chain_result_t r;
    r.kind = kind;
    r.code = code;
    r.count = count;
    r.last = last;
    expected_chain_results.insert(expected_chain_results.size(), r);
  endtask

  task automatic predict_chain_results(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic signed [COORD_W-1:0] z,
    input logic                      first,
    input logic                      final_pt
  );
    logic signed [CUBE_BITS-1:0]     cube[3];
    logic signed [CUBE_BITS:0]       delta[3];
    logic [csc_pkg::CODE_BITS-1:0]   code;
    logic                            jump;
    logic                            moved;
    cube[0] = snap_to_cube(x, inverse_size);
    cube[1] = snap_to_cube(y, inverse_size);
    cube[2] = snap_to_cube(z, inverse_size);
    jump = 1'b0;
    moved = 1'b0;
    if (first) begin
      prev_cube = cube;
      last_code = '0;
      last_code_valid = 1'b0;
      chain_failed = 1'b0;
      code_total = '0;
    end else if (chain_failed) begin
      return;
    end else begin
      for (int i = 0; i < 3; i++) begin
        delta[i] = cube[i] - prev_cube[i];
        if (delta[i] > 1 || delta[i] < -1) jump = 1'b1;
        if (delta[i] != 0) moved = 1'b1;
      end
      if (jump) begin
        chain_failed = 1'b1;
        push_result(csc_pkg::KIND_FAIL, '0, '0, 1'b1);
        return;
      end
      prev_cube = cube;
      if (moved) begin
        code = csc_pkg::CODE_BITS'((delta[0] + 1) + 3 * (delta[1] + 1)
                                   + 9 * (delta[2] + 1));
        if (!(last_code_valid && code == last_code)) begin
          last_code = code;
          last_code_valid = 1'b1;
          if (code_total != '1) code_total++;
          push_result(csc_pkg::KIND_STEP, code, '0, !final_pt);
        end
      end
    end
    if (final_pt)
      push_result(csc_pkg::KIND_DONE, '0, csc_pkg::CNT_OUT_BITS'(code_total), 1'b1);
  endtask

  always @(posedge clk) begin
    chain_result_t want;
    if (!rst_n) begin
      inverse_size = csc_pkg::INV_RESET;
      foreach (prev_cube[i]) prev_cube[i] = '0;
      last_code = '0;
      last_code_valid = 1'b0;
      chain_failed = 1'b0;
      code_total = '0;
      expected_chain_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chain_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result beat kind %0d code %0d count %0d last %0b",
                     $time, out_result_kind, out_step_code, out_code_count,
                     out_last_of_run);
          mismatches++;
        end else begin
          want = expected_chain_results.pop_front();
          case (want.kind)
            csc_pkg::KIND_STEP: step_beats++;
            csc_pkg::KIND_DONE: done_beats++;
            default:            fail_beats++;
          endcase
          if (out_result_kind !== want.kind || out_step_code !== want.code ||
              out_code_count !== want.count || out_last_of_run !== want.last) begin
            if (mismatches < 10)
              $display({"%0t: result mismatch, expected kind %0d code %0d count %0d",
                        " last %0b, got kind %0d code %0d count %0d last %0b"},
                       $time, want.kind, want.code, want.count, want.last,
                       out_result_kind, out_step_code, out_code_count,
                       out_last_of_run);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_chain_results(in_x_coord, in_y_coord, in_z_coord,
                              in_chain_first, in_chain_final);
      if (cfg_we) inverse_size = cfg_wdata;
    end
    pending_results <= expected_chain_results.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int IDLE_PCT       = 29;
  localparam int SETTLE_CYCLES  = 12;
  localparam int CALM_POINTS    = 100;
  localparam int COORD_MAX      = (1 << (csc_pkg::COORD_BITS_DEF - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (csc_pkg::COORD_BITS_DEF - 1));

  logic                                       clk;
  logic                                       rst_n;
  logic                                       cfg_we;
  logic [csc_pkg::INV_BITS-1:0]               cfg_wdata;
  logic                                       in_valid;
  logic                                       in_ready;
  logic signed [csc_pkg::COORD_BITS_DEF-1:0]  in_x_coord;
  logic signed [csc_pkg::COORD_BITS_DEF-1:0]  in_y_coord;
  logic signed [csc_pkg::COORD_BITS_DEF-1:0]  in_z_coord;
  logic                                       in_chain_first;
  logic                                       in_chain_final;
  logic                                       out_valid;
  logic                                       out_ready;
  logic [1:0]                                 out_result_kind;
  logic [csc_pkg::CODE_BITS-1:0]              out_step_code;
  logic [csc_pkg::CNT_OUT_BITS-1:0]           out_code_count;
  logic                                       out_last_of_run;

  int unsigned mismatches;
  int unsigned pending_results;
  int unsigned step_beats;
  int unsigned done_beats;
  int unsigned fail_beats;

  int unsigned points_sent;
  int unsigned settings_used;
  int unsigned stall_cycles;
  int unsigned inv_now;
  bit          calm;
  bit          hold_request;
  bit          hold_served;

  cube_step_chain_coder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_z_coord      (in_z_coord),
    .in_chain_first  (in_chain_first),
    .in_chain_final  (in_chain_final),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_step_code   (out_step_code),
    .out_code_count  (out_code_count),
    .out_last_of_run (out_last_of_run)
  );

  chain_code_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_z_coord      (in_z_coord),
    .in_chain_first  (in_chain_first),
    .in_chain_final  (in_chain_final),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_step_code   (out_step_code),
    .out_code_count  (out_code_count),
    .out_last_of_run (out_last_of_run),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .step_beats      (step_beats),
    .done_beats      (done_beats),
    .fail_beats      (fail_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("cube_step_chain_coder verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_point(input int x, input int y, input int z,
                            input bit first, input bit final_pt);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= x[csc_pkg::COORD_BITS_DEF-1:0];
    in_y_coord <= y[csc_pkg::COORD_BITS_DEF-1:0];
    in_z_coord <= z[csc_pkg::COORD_BITS_DEF-1:0];
    in_chain_first <= first;
    in_chain_final <= final_pt;
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    // points that give nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_inverse_size(input int unsigned value);
    cfg_we <= 1'b1;
    cfg_wdata <= value[csc_pkg::INV_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    inv_now = value;
    settings_used++;
  endtask

  task automatic random_chains(input int unsigned n_items);
    int cur[3];
    int step[3];
    int bound;
    int len;
    int next;
    int unsigned target;
    int unsigned r;
    // largest per-axis move that stays within one cube
    bound = (inv_now == 0) ? (1 << 18) : ((1 << 24) - 1) / inv_now;
    if (bound > (1 << 18)) bound = 1 << 18;
    target = points_sent + n_items;
    while (points_sent < target) begin
      if ($urandom_range(0, 99) < 8) begin
        send_point($urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(0, 99) < 10) cur[i] = $signed(24'($urandom));
          else cur[i] = $urandom_range(0, 1 << 23) - (1 << 22);
          step[i] = 0;
        end
        for (int k = 0; k < len; k++) begin
          if (k > 0) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
              // keep the last move, exercises repeated code suppression
            end else if (r < 37) begin
              step = '{0, 0, 0};
            end else if (r < 42) begin
              step[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 3 * bound : -3 * bound;
            end else begin
              for (int i = 0; i < 3; i++)
                step[i] = int'($urandom_range(0, 2 * bound)) - bound;
            end
            for (int i = 0; i < 3; i++) begin
              next = cur[i] + step[i];
              if (next > COORD_MAX || next < COORD_MIN) step[i] = -step[i];
              cur[i] = cur[i] + step[i];
            end
          end
          send_point(cur[0], cur[1], cur[2],
                     k == 0 && $urandom_range(0, 99) < 92,
                     k == len - 1 && $urandom_range(0, 99) < 90);
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_x_coord <= '0;
    in_y_coord <= '0;
    in_z_coord <= '0;
    in_chain_first <= 1'b0;
    in_chain_final <= 1'b0;
    inv_now = csc_pkg::INV_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // continuation from the reset cube, steps, repeated code, same cube
    send_point(0, 0, 0, 0, 0);
    send_point(1280, 0, 0, 0, 0);
    send_point(2560, 1280, -1280, 0, 0);
    send_point(3840, 2560, -2560, 0, 0);
    send_point(3840, 2560, -2560, 0, 0);
    send_point(5120, 3840, -1280, 0, 1);
    // single point chain at the coordinate extremes
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1, 1);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1, 0);
    send_point(8387327, 8387327, 8387327, 0, 0);
    // large jump, then a silenced final point
    send_point(0, 0, 0, 0, 0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 0, 1);
    send_point(-1, 1, 0, 1, 0);
    send_point(100000, 0, 0, 0, 1);
    // points after a chain end carry on the old chain
    send_point(0, 0, 0, 1, 1);
    send_point(-1280, -1280, -1280, 0, 0);
    send_point(-1280, -1280, -1280, 0, 1);
    send_point(0, 0, 0, 0, 0);
    // just either side of the rounding point
    send_point(640, -640, 0, 0, 0);
    send_point(641, -641, 0, 0, 0);
    send_point(0, 0, 0, 0, 1);
    drain_results();

    hold_request = 1'b1;
    random_chains(400);
    drain_results();
    set_inverse_size(16'hFFFF);
    random_chains(300);
    drain_results();
    set_inverse_size(1);
    random_chains(200);
    drain_results();
    set_inverse_size(0);
    random_chains(60);
    drain_results();
    set_inverse_size($urandom_range(1, 65535));
    random_chains(300);
    drain_results();
    set_inverse_size($urandom_range(200, 4000));
    random_chains(220);
    drain_results();

    // stretch with no idling on either side
    set_inverse_size(csc_pkg::INV_RESET);
    calm = 1'b1;
    random_chains(CALM_POINTS);
    calm = 1'b0;
    drain_results();

    $display("sent %0d points under %0d inverse cube size settings, last %0d with no idling",
             points_sent, settings_used + 1, CALM_POINTS);
    $display("checked %0d step codes, %0d chain ends, %0d chain failures",
             step_beats, done_beats, fail_beats);
    if (mismatches == 0 && pending_results == 0) begin
      $display("cube_step_chain_coder verification clean");
    end else begin
      $display("cube_step_chain_coder verification failed");
    end
    $finish;
  end

endmodule
